@@ design/yuvbgr_pkg.sv @@
// Package for the YUV 4:2:0 pixel-pair to BGR24 converter.
// Holds the item structs, the color coefficients and the fixed-point helper.
// No dependencies.
package yuvbgr_pkg;

	// Input item: two adjacent luma samples and their shared chroma pair
	typedef struct packed {
		logic [7:0] luma_left;
		logic [7:0] luma_right;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} yuv_item_t;

	// Result item: two pixels in memory byte order blue, green, red
	typedef struct packed {
		logic [7:0] left_blue;
		logic [7:0] left_green;
		logic [7:0] left_red;
		logic [7:0] right_blue;
		logic [7:0] right_green;
		logic [7:0] right_red;
	} bgr_item_t;

	// Coefficients in millionths
	localparam longint unsigned KR_MICRO  = 64'd1370705;
	localparam longint unsigned KGV_MICRO = 64'd698001;
	localparam longint unsigned KGU_MICRO = 64'd337633;
	localparam longint unsigned KB_MICRO  = 64'd1732446;
	localparam longint unsigned MICRO_ONE = 64'd1000000;
	localparam longint unsigned MICRO_HALF = 64'd500000;

	// Chroma offset and output scaling (times 220, drop 8 bits)
	localparam logic [8:0] CHROMA_OFFSET = 9'd128;
	localparam logic [15:0] SCALE_NUM = 16'd220;
	localparam logic [7:0] CHAN_MAX = 8'hFF;

	// Round a coefficient to frac fractional bits, halves up
	function automatic longint unsigned coef_fix(input longint unsigned micro,
			input int unsigned frac);
		longint unsigned one;
		one = 64'd1 << frac;
		return (micro * one + MICRO_HALF) / MICRO_ONE;
	endfunction

endpackage

@@ design/yuv420_to_bgr24_pixel_pair_core.sv @@
// Top level of the YUV 4:2:0 pixel-pair to BGR24 converter.
// Depends on yuvbgr_pkg, yuvbgr_front and yuvbgr_back.
//
// Usage:
//   The yuv channel takes one item per pixel pair: two adjacent luma samples
//   and the U/V pair they share. The bgr channel returns one item per input
//   item: blue, green, red of the left pixel, then of the right pixel, each
//   clamped to 0..255 and scaled by 220/256. Both channels use valid/ready.
//   Rows 2k and 2k+1 share chroma row k; the source does the addressing.
//
//   The pipeline has four stages (input register, coefficient products,
//   channel sums, clamp and scale). Throughput is one item per cycle while
//   the receiver takes results, with one multiplier per coefficient.
//
//   Reset clears the stage valid bits only; the pipeline starts empty.
//   When the receiver stalls, the last stage holds its item and bubbles
//   ahead of it close up; yuv_ready drops only once all four stages are full.
module yuv420_to_bgr24_pixel_pair_core #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  yuv_valid,
	output logic                  yuv_ready,
	input  yuvbgr_pkg::yuv_item_t yuv,
	output logic                  bgr_valid,
	input  logic                  bgr_ready,
	output yuvbgr_pkg::bgr_item_t bgr
);
	import yuvbgr_pkg::*;

	localparam int PW = COEF_FRAC_BITS + 10;

	logic                 prod_valid, prod_ready;
	logic [7:0]           y_left, y_right;
	logic signed [PW-1:0] p_b, p_r, p_gv, p_gu;

	yuvbgr_front #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.yuv_valid (yuv_valid),
		.yuv_ready (yuv_ready),
		.yuv       (yuv),
		.prod_valid(prod_valid),
		.prod_ready(prod_ready),
		.y_left    (y_left),
		.y_right   (y_right),
		.p_b       (p_b),
		.p_r       (p_r),
		.p_gv      (p_gv),
		.p_gu      (p_gu)
	);

	yuvbgr_back #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.prod_valid(prod_valid),
		.prod_ready(prod_ready),
		.y_left    (y_left),
		.y_right   (y_right),
		.p_b       (p_b),
		.p_r       (p_r),
		.p_gv      (p_gv),
		.p_gu      (p_gu),
		.bgr_valid (bgr_valid),
		.bgr_ready (bgr_ready),
		.bgr       (bgr)
	);

endmodule

@@ design/yuvbgr_front.sv @@
// Front half of the converter pipeline: input register and coefficient products.
// Stage 1 registers luma and centered chroma, stage 2 registers the four products.
// Depends on yuvbgr_pkg.
module yuvbgr_front #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            yuv_valid,
	output logic                            yuv_ready,
	input  yuvbgr_pkg::yuv_item_t           yuv,
	output logic                            prod_valid,
	input  logic                            prod_ready,
	output logic [7:0]                      y_left,
	output logic [7:0]                      y_right,
	output logic signed [COEF_FRAC_BITS+9:0] p_b,
	output logic signed [COEF_FRAC_BITS+9:0] p_r,
	output logic signed [COEF_FRAC_BITS+9:0] p_gv,
	output logic signed [COEF_FRAC_BITS+9:0] p_gu
);
	import yuvbgr_pkg::*;

	localparam int PW = COEF_FRAC_BITS + 10;
	localparam int unsigned FRAC = COEF_FRAC_BITS;
	localparam logic signed [PW-1:0] KR_S  = PW'(coef_fix(KR_MICRO, FRAC));
	localparam logic signed [PW-1:0] KGV_S = PW'(coef_fix(KGV_MICRO, FRAC));
	localparam logic signed [PW-1:0] KGU_S = PW'(coef_fix(KGU_MICRO, FRAC));
	localparam logic signed [PW-1:0] KB_S  = PW'(coef_fix(KB_MICRO, FRAC));

	logic              valid_s1, valid_s2;
	logic              en_s1, en_s2;
	logic [7:0]        yl_s1, yr_s1, yl_s2, yr_s2;
	logic signed [8:0] du_s1, dv_s1;
	logic signed [PW-1:0] pb_s2, pr_s2, pgv_s2, pgu_s2;

	// Advance a stage when it is empty or the one after it moves
	assign en_s2     = !valid_s2 || prod_ready;
	assign en_s1     = !valid_s1 || en_s2;
	assign yuv_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= yuv_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: hold luma, center chroma around zero
	always_ff @(posedge clk) begin
		if (en_s1) begin
			yl_s1 <= yuv.luma_left;
			yr_s1 <= yuv.luma_right;
			du_s1 <= $signed({1'b0, yuv.chroma_blue} - CHROMA_OFFSET);
			dv_s1 <= $signed({1'b0, yuv.chroma_red} - CHROMA_OFFSET);
		end
	end

	// Stage 2: one product per coefficient, shared by both pixels
	always_ff @(posedge clk) begin
		if (en_s2) begin
			yl_s2  <= yl_s1;
			yr_s2  <= yr_s1;
			pb_s2  <= KB_S * PW'(du_s1);
			pr_s2  <= KR_S * PW'(dv_s1);
			pgv_s2 <= KGV_S * PW'(dv_s1);
			pgu_s2 <= KGU_S * PW'(du_s1);
		end
	end

	assign prod_valid = valid_s2;
	assign y_left     = yl_s2;
	assign y_right    = yr_s2;
	assign p_b        = pb_s2;
	assign p_r        = pr_s2;
	assign p_gv       = pgv_s2;
	assign p_gu       = pgu_s2;

endmodule

@@ design/yuvbgr_back.sv @@
// Back half of the converter pipeline: channel sums, clamp and output scaling.
// Stage 3 registers the six fixed-point sums, stage 4 the finished result item.
// Depends on yuvbgr_pkg.
module yuvbgr_back #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             prod_valid,
	output logic                             prod_ready,
	input  logic [7:0]                       y_left,
	input  logic [7:0]                       y_right,
	input  logic signed [COEF_FRAC_BITS+9:0] p_b,
	input  logic signed [COEF_FRAC_BITS+9:0] p_r,
	input  logic signed [COEF_FRAC_BITS+9:0] p_gv,
	input  logic signed [COEF_FRAC_BITS+9:0] p_gu,
	output logic                             bgr_valid,
	input  logic                             bgr_ready,
	output yuvbgr_pkg::bgr_item_t            bgr
);
	import yuvbgr_pkg::*;

	localparam int F  = COEF_FRAC_BITS;
	localparam int AW = COEF_FRAC_BITS + 11;

	// Floor, clamp to 0..255, then scale by 220/256
	function automatic logic [7:0] chan_finish(input logic signed [AW-1:0] acc);
		logic [AW-F-1:0] whole;
		logic [7:0]      c;
		logic [15:0]     sc;
		whole = acc[AW-1:F];
		if (acc[AW-1]) begin
			c = 8'd0;
		end else if (|whole[AW-F-1:8]) begin
			c = CHAN_MAX;
		end else begin
			c = whole[7:0];
		end
		sc = 16'(c) * SCALE_NUM;
		return sc[15:8];
	endfunction

	logic                 valid_s3, valid_s4;
	logic                 en_s3, en_s4;
	logic signed [AW-1:0] base_l, base_r;
	logic signed [AW-1:0] sum [6];
	logic signed [AW-1:0] acc_s3 [6];
	bgr_item_t            bgr_s4;

	// Advance a stage when it is empty or the one after it moves
	assign en_s4      = !valid_s4 || bgr_ready;
	assign en_s3      = !valid_s3 || en_s4;
	assign prod_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= prod_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Form the six channel sums in blue, green, red order per pixel
	always_comb begin
		base_l = AW'({y_left, {F{1'b0}}});
		base_r = AW'({y_right, {F{1'b0}}});
		sum[0] = base_l + AW'(p_b);
		sum[1] = base_l - AW'(p_gv) - AW'(p_gu);
		sum[2] = base_l + AW'(p_r);
		sum[3] = base_r + AW'(p_b);
		sum[4] = base_r - AW'(p_gv) - AW'(p_gu);
		sum[5] = base_r + AW'(p_r);
	end

	// Stage 3: hold the sums
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < 6; i++) begin
				acc_s3[i] <= sum[i];
			end
		end
	end

	// Stage 4: finish each channel into the result item
	always_ff @(posedge clk) begin
		if (en_s4) begin
			bgr_s4.left_blue   <= chan_finish(acc_s3[0]);
			bgr_s4.left_green  <= chan_finish(acc_s3[1]);
			bgr_s4.left_red    <= chan_finish(acc_s3[2]);
			bgr_s4.right_blue  <= chan_finish(acc_s3[3]);
			bgr_s4.right_green <= chan_finish(acc_s3[4]);
			bgr_s4.right_red   <= chan_finish(acc_s3[5]);
		end
	end

	assign bgr_valid = valid_s4;
	assign bgr       = bgr_s4;

endmodule

@@ design/yuvbgr_check.sv @@
// Port-level checks for the YUV 4:2:0 pixel-pair to BGR24 converter.
// Bound to the top level below; depends on yuvbgr_pkg.
module yuvbgr_check (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  yuv_valid,
	input logic                  yuv_ready,
	input logic                  bgr_valid,
	input logic                  bgr_ready,
	input yuvbgr_pkg::bgr_item_t bgr
);
	import yuvbgr_pkg::*;

	// A stalled result item holds
	a_bgr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bgr_valid && !bgr_ready |=> bgr_valid && $stable(bgr))
		else $error("bgr item changed or dropped while stalled");

	// Scaled channels never exceed 219
	a_bgr_range: assert property (@(posedge clk) disable iff (!arst_n)
		bgr_valid |-> bgr.left_blue <= 8'd219 && bgr.left_green <= 8'd219 &&
			bgr.left_red <= 8'd219 && bgr.right_blue <= 8'd219 &&
			bgr.right_green <= 8'd219 && bgr.right_red <= 8'd219)
		else $error("bgr channel above 219");

	// An open output never blocks the input
	a_no_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		bgr_ready |-> yuv_ready)
		else $error("yuv_ready low while bgr_ready high");

	// An accepted item reaches bgr_valid while the output keeps flowing
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(yuv_valid && yuv_ready ##1 bgr_ready ##1 bgr_ready ##1 bgr_ready)
			|=> bgr_valid)
		else $error("result item missing after four cycles");

endmodule

bind yuv420_to_bgr24_pixel_pair_core yuvbgr_check u_yuvbgr_check (.*);

@@ tb/sv/yuv420_to_bgr24_pixel_pair_core_tb.sv @@
// Testbench for the YUV 4:2:0 pixel-pair to BGR24 converter core.
// Predicts every BGR item in a small scoreboard class and drives both valid/ready channels.
// Depends on yuvbgr_pkg and yuv420_to_bgr24_pixel_pair_core.
module yuv420_to_bgr24_pixel_pair_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import yuvbgr_pkg::*;

	localparam int FRAC = 16;
	localparam longint COEF_UNIT = longint'(1) << FRAC;
	localparam int RANDOM_ITEMS = 800;
	localparam int BURST_ITEMS = 30;
	localparam int LONG_HOLD = 120;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP = 40;

	// Round a coefficient given in millionths to FRAC fraction bits, halves up
	function automatic longint fixed_coef(input longint micro);
		return (micro * COEF_UNIT + 64'sd500000) / 64'sd1000000;
	endfunction

	localparam longint K_RED   = fixed_coef(64'sd1370705);
	localparam longint K_GRN_V = fixed_coef(64'sd698001);
	localparam longint K_GRN_U = fixed_coef(64'sd337633);
	localparam longint K_BLUE  = fixed_coef(64'sd1732446);

	// Corner cases: {luma_left, luma_right, chroma_blue, chroma_red}
	localparam int N_CORNERS = 21;
	localparam logic [31:0] CORNER_CASES [N_CORNERS] = '{
		32'h0000_8080, 32'hFFFF_8080, 32'h00FF_0000, 32'hFF00_FFFF,
		32'h0000_00FF, 32'hFFFF_FF00, 32'h00FF_FF00, 32'hFF00_00FF,
		32'h10EB_8080, 32'h8080_0080, 32'h8080_FF80, 32'h8080_8000,
		32'h8080_80FF, 32'h01FE_7F81, 32'h0000_FFFF, 32'hFFFF_0000,
		32'h5191_5AF0, 32'h29D2_F06E, 32'hAA6A_A610, 32'hAA55_AA55,
		32'h55AA_55AA
	};

	logic      clk;
	logic      arst_n;
	logic      yuv_valid;
	logic      yuv_ready;
	yuv_item_t yuv;
	logic      bgr_valid;
	logic      bgr_ready;
	bgr_item_t bgr;

	bit rx_idling;
	bit long_hold_req;
	int items_sent;

	// Expected BGR items in order, with the fixed-point conversion that makes them
	class bgr_scoreboard;
		bgr_item_t pending_bgr[$];
		int mismatches;
		int results_seen;

		function automatic logic [7:0] finish_channel(input longint sum);
			longint level;
			if (sum < 0)
				return 8'd0;
			level = sum >>> FRAC;
			if (level > 255)
				level = 255;
			return 8'((level * 220) >> 8);
		endfunction

		function automatic bgr_item_t convert_pair(input yuv_item_t px);
			bgr_item_t res;
			longint du, dv, y_left, y_right, blue_off, green_off, red_off;
			du = longint'(px.chroma_blue) - 128;
			dv = longint'(px.chroma_red) - 128;
			y_left = longint'(px.luma_left) << FRAC;
			y_right = longint'(px.luma_right) << FRAC;
			blue_off = K_BLUE * du;
			green_off = -(K_GRN_V * dv) - K_GRN_U * du;
			red_off = K_RED * dv;
			res.left_blue = finish_channel(y_left + blue_off);
			res.left_green = finish_channel(y_left + green_off);
			res.left_red = finish_channel(y_left + red_off);
			res.right_blue = finish_channel(y_right + blue_off);
			res.right_green = finish_channel(y_right + green_off);
			res.right_red = finish_channel(y_right + red_off);
			return res;
		endfunction

		function int pending();
			return pending_bgr.size();
		endfunction

		task take_yuv(input yuv_item_t px);
			pending_bgr.push_back(convert_pair(px));
		endtask

		task report(input string what, input int got, input int want);
			if (mismatches < PRINT_CAP)
				$display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_bgr(input bgr_item_t got);
			bgr_item_t want;
			results_seen++;
			if (pending_bgr.size() == 0) begin
				report("unexpected bgr item, pending count", 0, 0);
				return;
			end
			want = pending_bgr.pop_front();
			if (got.left_blue != want.left_blue)
				report("left_blue", got.left_blue, want.left_blue);
			if (got.left_green != want.left_green)
				report("left_green", got.left_green, want.left_green);
			if (got.left_red != want.left_red)
				report("left_red", got.left_red, want.left_red);
			if (got.right_blue != want.right_blue)
				report("right_blue", got.right_blue, want.right_blue);
			if (got.right_green != want.right_green)
				report("right_green", got.right_green, want.right_green);
			if (got.right_red != want.right_red)
				report("right_red", got.right_red, want.right_red);
		endtask
	endclass

	bgr_scoreboard sb = new;

	yuv420_to_bgr24_pixel_pair_core #(
		.COEF_FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.yuv_valid(yuv_valid),
		.yuv_ready(yuv_ready),
		.yuv(yuv),
		.bgr_valid(bgr_valid),
		.bgr_ready(bgr_ready),
		.bgr(bgr)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Bias samples toward the ends of the range
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(0, 15));
			3: return 8'($urandom_range(240, 255));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic yuv_item_t random_pair();
		yuv_item_t px;
		px.luma_left = pick_sample();
		px.luma_right = pick_sample();
		px.chroma_blue = pick_sample();
		px.chroma_red = pick_sample();
		return px;
	endfunction

	function automatic int pick_gap(input bit idling);
		if (idling && $urandom_range(0, 4) == 0)
			return $urandom_range(1, 19);
		return 0;
	endfunction

	// Offer one item, hold it until accepted, then idle for the given gap
	task automatic send_yuv(input yuv_item_t px, input int gap);
		yuv <= px;
		yuv_valid <= 1'b1;
		do @(posedge clk); while (!yuv_ready);
		sb.take_yuv(px);
		items_sent++;
		if (gap > 0) begin
			yuv_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every predicted item has come back
	task automatic wait_drained();
		yuv_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Receiver: check accepted items, stall in random bursts or one long hold
	initial begin
		int hold_left;
		int long_left;
		hold_left = 0;
		long_left = 0;
		bgr_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (bgr_valid && bgr_ready)
				sb.check_bgr(bgr);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				long_left = LONG_HOLD;
			end
			if (long_left > 0) begin
				long_left--;
				bgr_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				bgr_ready <= 1'b0;
			end else if (rx_idling && $urandom_range(0, 4) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				bgr_ready <= 1'b0;
			end else begin
				bgr_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d items pending", cycles, sb.pending());
		$display("FAILURE");
		$finish;
	end

	// Stimulus
	initial begin
		bit idling;
		arst_n <= 1'b0;
		yuv_valid <= 1'b0;
		yuv <= '0;
		rx_idling = 1'b1;
		long_hold_req = 1'b0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases: range ends, neutral chroma, saturation and negative sums
		for (int i = 0; i < N_CORNERS; i++)
			send_yuv(yuv_item_t'(CORNER_CASES[i]), pick_gap(1'b1));
		wait_drained();

		// Hold the receiver off while items keep coming so the pipeline backs up
		long_hold_req = 1'b1;
		for (int i = 0; i < BURST_ITEMS; i++)
			send_yuv(random_pair(), 0);
		wait_drained();

		// Random items: idle bursts, a quiet stretch, one full drain, quiet tail
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			idling = (i < 300) || (i >= 400 && i < 650);
			rx_idling = idling;
			if (i == 500)
				wait_drained();
			send_yuv(random_pair(), pick_gap(idling));
		end

		rx_idling = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixel pairs (%0d corner cases, one backed-up burst), checked %0d results",
			items_sent, N_CORNERS, sb.results_seen);
		$display("Field mismatches: %0d, items still pending: %0d", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ yuv420_to_bgr24_pixel_pair_core.f @@
design/yuvbgr_pkg.sv
design/yuvbgr_front.sv
design/yuvbgr_back.sv
design/yuv420_to_bgr24_pixel_pair_core.sv
design/yuvbgr_check.sv
tb/sv/yuv420_to_bgr24_pixel_pair_core_tb.sv
